[hw/rtl/lecb_pkg.sv]
package lecb_pkg;

    localparam int POS_W     = 9;
    localparam int CP_W      = 21;
    localparam int WC_W      = 2;
    localparam int LEN_OUT_W = 9;
    localparam int TW_W      = 10;

    localparam logic [WC_W-1:0] WC_WIDE = 2'd2;

    typedef enum logic [2:0] {
        REQ_CLEAR    = 3'd0,
        REQ_INSERT   = 3'd1,
        REQ_READ     = 3'd2,
        REQ_DEL_AT   = 3'd3,
        REQ_DEL_LEFT = 3'd4,
        REQ_CUT      = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

endpackage

[hw/rtl/line_edit_char_buffer.sv]
// Line edit character buffer: holds up to CAPACITY code points, each with a wide mark, in a
// single-port-write, registered-read memory, plus the line length and a running count of wide
// characters. One request is taken at a time. A request runs through a small sequencer that
// moves one memory entry per cycle through the read port and the write port. A read reads one
// entry; insert, delete at, delete left and cut read up to CAPACITY entries; and clear, a
// refused request, an append, or delete left of the end reads none. A finished result waits
// in the output register until its transfer, and the next request is taken once it has left
// the sequencer.
module line_edit_char_buffer #(
    parameter int CAPACITY = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_req_type,
    input  logic [lecb_pkg::POS_W-1:0]      i_position,
    input  logic [lecb_pkg::CP_W-1:0]       i_code_point,
    input  logic [lecb_pkg::WC_W-1:0]       i_width_class,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_status,
    output logic [lecb_pkg::CP_W-1:0]       o_char_out,
    output logic                            o_wide_out,
    output logic [lecb_pkg::WC_W-1:0]       o_inserted_width,
    output logic [lecb_pkg::LEN_OUT_W-1:0]  o_line_length,
    output logic [lecb_pkg::TW_W-1:0]       o_total_width
);

    import lecb_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam int SW = (LW + 1 > TW_W) ? LW + 1 : TW_W;
    localparam int MW = CP_W + 1;

    logic [MW-1:0]        mem [CAPACITY];
    logic [MW-1:0]        r_rdata;

    t_state               r_state, n_state;
    t_req                 r_op;
    logic                 r_status;
    logic [POS_W-1:0]     r_pos;
    logic [CP_W-1:0]      r_cp;
    logic [WC_W-1:0]      r_wc;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        r_wcnt;
    logic [LW-1:0]        r_newlen;
    logic [LW-1:0]        r_cnt;
    logic [LW-1:0]        r_acc;
    logic [AW-1:0]        r_src;
    logic [AW-1:0]        r_dst;
    logic                 r_first;
    logic                 r_pv;
    logic                 r_pwr;
    logic                 r_pacc;
    logic [AW-1:0]        r_pdst;
    logic [CP_W-1:0]      r_char;
    logic                 r_wide;

    logic                 r_ovalid;
    logic                 r_ostatus;
    logic [CP_W-1:0]      r_ochar;
    logic                 r_owide;
    logic [WC_W-1:0]      r_oecho;
    logic [LEN_OUT_W-1:0] r_olen;
    logic [TW_W-1:0]      r_otw;

    logic                 accept;
    logic                 issue;
    logic                 fire;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MW-1:0]        wr_data;
    logic                 issue_wr;
    logic                 issue_acc;
    logic [CW-1:0]        pos_e;
    logic [CW-1:0]        len_e;
    logic [LW-1:0]        pos_l;
    logic [LW-1:0]        fin_len;
    logic [LW-1:0]        fin_wcnt;
    logic [SW-1:0]        fin_sum;
    logic [CW-1:0]        fin_len_e;

    assign pos_e = CW'(i_position);
    assign len_e = CW'(r_len);
    assign pos_l = LW'(i_position);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_cnt == '0 && !r_pv) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_ovalid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        accept    = o_ready && i_valid;
        issue     = (r_state == ST_SWEEP) && (r_cnt != '0);
        fire      = (r_state == ST_FINISH) && (!r_ovalid || i_ready);
        issue_wr  = 1'b0;
        issue_acc = 1'b0;
        unique case (r_op)
            REQ_INSERT:   issue_wr = 1'b1;
            REQ_DEL_AT: begin
                issue_wr  = !r_first;
                issue_acc = r_first;
            end
            REQ_DEL_LEFT: begin
                issue_wr  = 1'b1;
                issue_acc = 1'b1;
            end
            REQ_CUT:      issue_acc = 1'b1;
            default: begin
                issue_wr  = 1'b0;
                issue_acc = 1'b0;
            end
        endcase
        if (r_pv && r_pwr) begin
            wr_en   = 1'b1;
            wr_addr = r_pdst;
            wr_data = r_rdata;
        end else begin
            wr_en   = fire && (r_op == REQ_INSERT) && !r_status;
            wr_addr = AW'(r_pos);
            wr_data = {(r_wc == WC_WIDE), r_cp};
        end
    end

    always_comb begin
        fin_len  = r_len;
        fin_wcnt = r_wcnt;
        if (!r_status) begin
            fin_len = r_newlen;
            unique case (r_op)
                REQ_CLEAR:    fin_wcnt = '0;
                REQ_INSERT:   fin_wcnt = r_wcnt + LW'(r_wc == WC_WIDE);
                REQ_DEL_AT:   fin_wcnt = r_wcnt - r_acc;
                REQ_DEL_LEFT: fin_wcnt = r_acc;
                REQ_CUT:      fin_wcnt = r_wcnt - r_acc;
                default:      fin_wcnt = r_wcnt;
            endcase
        end
        fin_sum   = SW'(fin_len) + SW'(fin_wcnt);
        fin_len_e = CW'(fin_len);
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_src];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_wcnt   <= '0;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (accept) begin
                r_op     <= t_req'(i_req_type);
                r_pos    <= i_position;
                r_cp     <= i_code_point;
                r_wc     <= i_width_class;
                r_status <= 1'b1;
                r_newlen <= r_len;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_first  <= 1'b1;
                r_char   <= '0;
                r_wide   <= 1'b0;
                r_src    <= AW'(i_position);
                r_dst    <= '0;
                unique case (i_req_type)
                    REQ_CLEAR: begin
                        r_status <= 1'b0;
                        r_newlen <= '0;
                    end
                    REQ_INSERT: begin
                        if (r_len < LW'(CAPACITY) && pos_e <= len_e) begin
                            r_status <= 1'b0;
                            r_newlen <= r_len + 1'b1;
                            r_cnt    <= r_len - pos_l;
                            r_src    <= AW'(r_len - 1'b1);
                            r_dst    <= AW'(r_len);
                        end
                    end
                    REQ_READ: begin
                        if (pos_e < len_e) begin
                            r_status <= 1'b0;
                            r_cnt    <= LW'(1);
                        end
                    end
                    REQ_DEL_AT: begin
                        if (pos_e < len_e) begin
                            r_status <= 1'b0;
                            r_newlen <= r_len - 1'b1;
                            r_cnt    <= r_len - pos_l;
                            r_dst    <= AW'(pos_l - 1'b1);
                        end
                    end
                    REQ_DEL_LEFT: begin
                        if (pos_e == '0) begin
                            r_status <= 1'b1;
                        end else if (pos_e == len_e) begin
                            r_status <= 1'b0;
                            r_newlen <= '0;
                        end else if (pos_e < len_e) begin
                            r_status <= 1'b0;
                            r_newlen <= r_len - pos_l;
                            r_cnt    <= r_len - pos_l;
                        end
                    end
                    REQ_CUT: begin
                        if (pos_e < len_e) begin
                            r_status <= 1'b0;
                            r_newlen <= pos_l;
                            r_cnt    <= r_len - pos_l;
                        end
                    end
                    default: r_status <= 1'b1;
                endcase
            end

            if (issue) begin
                r_cnt   <= r_cnt - 1'b1;
                r_first <= 1'b0;
                r_pdst  <= r_dst;
                r_pwr   <= issue_wr;
                r_pacc  <= issue_acc;
                if (r_op == REQ_INSERT) begin
                    r_src <= r_src - 1'b1;
                    r_dst <= r_dst - 1'b1;
                end else begin
                    r_src <= r_src + 1'b1;
                    r_dst <= r_dst + 1'b1;
                end
            end
            r_pv <= issue;

            if (r_pv) begin
                if (r_pacc) begin
                    r_acc <= r_acc + LW'(r_rdata[MW-1]);
                end
                if (r_op == REQ_READ) begin
                    r_char <= r_rdata[CP_W-1:0];
                    r_wide <= r_rdata[MW-1];
                end
            end

            if (fire) begin
                r_len     <= fin_len;
                r_wcnt    <= fin_wcnt;
                r_ovalid  <= 1'b1;
                r_ostatus <= r_status;
                r_ochar   <= r_char;
                r_owide   <= r_wide;
                r_oecho   <= (r_op == REQ_INSERT && !r_status) ? r_wc : '0;
                r_olen    <= fin_len_e[LEN_OUT_W-1:0];
                r_otw     <= fin_sum[TW_W-1:0];
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_char_out       = r_ochar;
    assign o_wide_out       = r_owide;
    assign o_inserted_width = r_oecho;
    assign o_line_length    = r_olen;
    assign o_total_width    = r_otw;

endmodule

[test/line_edit_char_buffer_checker.sv]
`timescale 1ns / 1ps
module line_edit_char_buffer_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    input  logic [2:0]                     i_req_type,
    input  logic [lecb_pkg::POS_W-1:0]     i_position,
    input  logic [lecb_pkg::CP_W-1:0]      i_code_point,
    input  logic [lecb_pkg::WC_W-1:0]      i_width_class,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic                           i_status,
    input  logic [lecb_pkg::CP_W-1:0]      i_char_out,
    input  logic                           i_wide_out,
    input  logic [lecb_pkg::WC_W-1:0]      i_inserted_width,
    input  logic [lecb_pkg::LEN_OUT_W-1:0] i_line_length,
    input  logic [lecb_pkg::TW_W-1:0]      i_total_width,
    output int unsigned                    o_fail_count,
    output int unsigned                    o_checked,
    output int unsigned                    o_line_len
);
    import lecb_pkg::*;

    typedef struct packed {
        logic                 status;
        logic [CP_W-1:0]      char_read;
        logic                 wide_read;
        logic [WC_W-1:0]      echo;
        logic [LEN_OUT_W-1:0] length;
        logic [TW_W-1:0]      width_sum;
    } t_line_result;

    logic [CP_W-1:0] char_mem [CAPACITY];
    logic            wide_mem [CAPACITY];
    int unsigned     held;
    int unsigned     fails;
    int unsigned     results_seen;
    t_line_result    awaited_q [$];

    function automatic t_line_result apply_edit(input logic [2:0] req, input int unsigned pos,
                                                input logic [CP_W-1:0] cp,
                                                input logic [WC_W-1:0] wc);
        t_line_result res;
        int unsigned  i;
        int unsigned  width_sum;
        res = '0;
        res.status = 1'b1;
        case (req)
            REQ_CLEAR: begin
                held = 0;
                res.status = 1'b0;
            end
            REQ_INSERT: begin
                if (held < CAPACITY && pos <= held) begin
                    for (i = held; i > pos; i--) begin
                        char_mem[i] = char_mem[i - 1];
                        wide_mem[i] = wide_mem[i - 1];
                    end
                    char_mem[pos] = cp;
                    wide_mem[pos] = (wc == WC_WIDE);
                    held++;
                    res.echo = wc;
                    res.status = 1'b0;
                end
            end
            REQ_READ: begin
                if (pos < held) begin
                    res.char_read = char_mem[pos];
                    res.wide_read = wide_mem[pos];
                    res.status = 1'b0;
                end
            end
            REQ_DEL_AT: begin
                if (pos < held) begin
                    for (i = pos; i + 1 < held; i++) begin
                        char_mem[i] = char_mem[i + 1];
                        wide_mem[i] = wide_mem[i + 1];
                    end
                    held--;
                    res.status = 1'b0;
                end
            end
            REQ_DEL_LEFT: begin
                if (pos != 0 && pos == held) begin
                    held = 0;
                    res.status = 1'b0;
                end else if (pos != 0 && pos < held) begin
                    for (i = 0; i < held - pos; i++) begin
                        char_mem[i] = char_mem[i + pos];
                        wide_mem[i] = wide_mem[i + pos];
                    end
                    held = held - pos;
                    res.status = 1'b0;
                end
            end
            REQ_CUT: begin
                if (pos < held) begin
                    held = pos;
                    res.status = 1'b0;
                end
            end
            default: ;
        endcase
        width_sum = 0;
        for (i = 0; i < held; i++) begin
            width_sum += wide_mem[i] ? 2 : 1;
        end
        res.length = LEN_OUT_W'(held);
        res.width_sum = TW_W'(width_sum);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fails++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_line_result want;
        if (!i_rst_n) begin
            held = 0;
            awaited_q.delete();
        end else begin
            // A result transfer always belongs to an earlier request, so it is
            // checked before any request taken at the same edge.
            if (i_res_valid && i_res_ready) begin
                results_seen++;
                if (awaited_q.size() == 0) begin
                    fails++;
                    $error("Result transfer with no request outstanding");
                end else begin
                    want = awaited_q.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("char_out", want.char_read, i_char_out);
                    check_field("wide_out", want.wide_read, i_wide_out);
                    check_field("inserted_width", want.echo, i_inserted_width);
                    check_field("line_length", want.length, i_line_length);
                    check_field("total_width", want.width_sum, i_total_width);
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_q.push_back(apply_edit(i_req_type, i_position, i_code_point,
                                               i_width_class));
            end
        end
        o_fail_count <= fails;
        o_checked <= results_seen;
        o_line_len <= held;
    end

endmodule

[test/tb_line_edit_char_buffer.sv]
`timescale 1ns / 1ps
module tb_line_edit_char_buffer;
    import lecb_pkg::*;

    localparam int CAPACITY = 256;
    localparam int RANDOM_EDITS = 1200;
    localparam int STALL_CYCLES = 800;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 2_500_000;

    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [2:0]           req_type = REQ_CLEAR;
    logic [POS_W-1:0]     req_pos = '0;
    logic [CP_W-1:0]      req_cp = '0;
    logic [WC_W-1:0]      req_wc = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic                 res_status;
    logic [CP_W-1:0]      res_char;
    logic                 res_wide;
    logic [WC_W-1:0]      res_echo;
    logic [LEN_OUT_W-1:0] res_length;
    logic [TW_W-1:0]      res_width;

    int unsigned fail_count;
    int unsigned checked;
    int unsigned line_len;
    int unsigned sent [8];
    int unsigned edits_sent;
    int unsigned total_sent;
    bit          steady = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    line_edit_char_buffer #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_ready          (req_ready),
        .i_req_type       (req_type),
        .i_position       (req_pos),
        .i_code_point     (req_cp),
        .i_width_class    (req_wc),
        .o_valid          (res_valid),
        .i_ready          (res_ready),
        .o_status         (res_status),
        .o_char_out       (res_char),
        .o_wide_out       (res_wide),
        .o_inserted_width (res_echo),
        .o_line_length    (res_length),
        .o_total_width    (res_width)
    );

    line_edit_char_buffer_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_ready      (req_ready),
        .i_req_type       (req_type),
        .i_position       (req_pos),
        .i_code_point     (req_cp),
        .i_width_class    (req_wc),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_status         (res_status),
        .i_char_out       (res_char),
        .i_wide_out       (res_wide),
        .i_inserted_width (res_echo),
        .i_line_length    (res_length),
        .i_total_width    (res_width),
        .o_fail_count     (fail_count),
        .o_checked        (checked),
        .o_line_len       (line_len)
    );

    function automatic logic [CP_W-1:0] random_code_point();
        return CP_W'($urandom());
    endfunction

    function automatic logic [WC_W-1:0] random_width();
        return WC_W'($urandom_range(0, 3));
    endfunction

    // The line length seen here lags by one request, which only shifts the spread of positions.
    function automatic logic [POS_W-1:0] pick_position(input int unsigned len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return POS_W'(len);
        if (r < 20) return POS_W'(len == 0 ? 0 : len - 1);
        if (r < 30) return POS_W'($urandom());
        return POS_W'($urandom_range(0, len));
    endfunction

    task automatic send_request(input logic [2:0] req, input logic [POS_W-1:0] pos,
                                input logic [CP_W-1:0] cp, input logic [WC_W-1:0] wc);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < 33) gap++;
        if ($urandom_range(0, 19) == 0) gap += $urandom_range(20, 300);
        if (steady) gap = 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= req;
        req_pos <= pos;
        req_cp <= cp;
        req_wc <= wc;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent[req]++;
        total_sent++;
        if (req <= REQ_CUT) edits_sent++;
    endtask

    task automatic random_edit();
        int unsigned len;
        int unsigned r;
        len = line_len;
        r = $urandom_range(0, 99);
        // Long lines are cut back so that most shifts stay short.
        if (len > 48 && r < 38) r = 80;
        if (r < 38) begin
            send_request(REQ_INSERT, pick_position(len), random_code_point(), random_width());
        end else if (r < 56) begin
            send_request(REQ_READ, pick_position(len), random_code_point(), random_width());
        end else if (r < 68) begin
            send_request(REQ_DEL_AT, pick_position(len), random_code_point(), random_width());
        end else if (r < 76) begin
            send_request(REQ_DEL_LEFT, pick_position(len), random_code_point(), random_width());
        end else if (r < 84) begin
            send_request(REQ_CUT, pick_position(len), random_code_point(), random_width());
        end else if (r < 88) begin
            send_request(REQ_CLEAR, pick_position(len), random_code_point(), random_width());
        end else if (r < 92) begin
            send_request($urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO,
                         POS_W'($urandom()), random_code_point(), random_width());
        end else begin
            send_request(3'($urandom_range(0, 7)), POS_W'($urandom()), random_code_point(),
                         random_width());
        end
    endtask

    task automatic fill_line(input bit all_wide);
        while (line_len < CAPACITY) begin
            send_request(REQ_INSERT, POS_W'($urandom_range(0, line_len)), random_code_point(),
                         all_wide ? WC_WIDE : random_width());
        end
        send_request(REQ_INSERT, '0, random_code_point(), WC_WIDE);
        send_request(REQ_INSERT, POS_W'(CAPACITY), random_code_point(), random_width());
        send_request(REQ_READ, POS_W'(CAPACITY - 1), random_code_point(), random_width());
        send_request(REQ_READ, POS_W'(CAPACITY), random_code_point(), random_width());
        send_request(REQ_DEL_AT, '0, random_code_point(), random_width());
        send_request(REQ_INSERT, POS_W'(CAPACITY - 1), random_code_point(), WC_WIDE);
        send_request(REQ_READ, '0, random_code_point(), random_width());
        send_request(REQ_DEL_LEFT, POS_W'(CAPACITY / 2), random_code_point(), random_width());
        send_request(REQ_DEL_LEFT, POS_W'(CAPACITY / 2), random_code_point(), random_width());
        send_request(REQ_READ, '0, random_code_point(), random_width());
    endtask

    initial begin : result_side
        bit stalled;
        stalled = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            // Holding the result side off lets the block fill up and stall its input.
            if (!stalled && checked >= 60) begin
                stalled = 1'b1;
                res_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end else begin
                res_ready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb_line_edit_char_buffer NOT OK");
        $finish;
    end

    initial begin : stimulus
        int unsigned base;
        int unsigned fills;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_request(REQ_READ, '0, '0, '0);
        send_request(REQ_DEL_AT, '0, '0, '0);
        send_request(REQ_DEL_LEFT, '0, '0, '0);
        send_request(REQ_DEL_LEFT, 9'd1, '0, '0);
        send_request(REQ_CUT, '0, '0, '0);
        send_request(REQ_INSERT, 9'd1, 21'h12345, 2'd1);
        send_request(REQ_INSERT, '0, '1, WC_WIDE);
        send_request(REQ_INSERT, '0, '0, 2'd0);
        send_request(REQ_INSERT, 9'd2, 21'h10FFFF, 2'd3);
        send_request(REQ_INSERT, 9'd1, 21'h155555, 2'd1);
        send_request(REQ_INSERT, 9'd4, 21'h0AAAAA, WC_WIDE);
        for (int i = 0; i <= 5; i++) begin
            send_request(REQ_READ, POS_W'(i), '0, '0);
        end
        send_request(REQ_READ, '1, '1, '1);
        send_request(REQ_UNUSED_LO, '1, '1, '1);
        send_request(REQ_UNUSED_HI, '0, '0, '0);
        send_request(REQ_DEL_AT, 9'd1, '0, '0);
        send_request(REQ_DEL_LEFT, 9'd1, '0, '0);
        send_request(REQ_CUT, 9'd2, '0, '0);
        send_request(REQ_DEL_LEFT, 9'd2, '0, '0);
        send_request(REQ_CLEAR, '1, '1, '1);

        base = edits_sent;
        fills = 0;
        while (edits_sent - base < RANDOM_EDITS) begin
            if (fills < 2 && edits_sent - base >= 300 + fills * 500) begin
                fill_line(fills == 0);
                fills++;
            end
            steady = (edits_sent - base >= 500) && (edits_sent - base < 700);
            random_edit();
        end
        steady = 1'b0;
        req_valid <= 1'b0;

        wait (checked == total_sent);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests: %0d clear, %0d insert, %0d read, %0d delete, %0d delete-left,",
                 total_sent, sent[REQ_CLEAR], sent[REQ_INSERT], sent[REQ_READ],
                 sent[REQ_DEL_AT], sent[REQ_DEL_LEFT]);
        $display("%0d cut, %0d unused codes; %0d results compared, two fills to %0d characters.",
                 sent[REQ_CUT], sent[REQ_UNUSED_LO] + sent[REQ_UNUSED_HI], checked, CAPACITY);
        if (fail_count == 0) begin
            $display("tb_line_edit_char_buffer OK");
        end else begin
            $display("tb_line_edit_char_buffer NOT OK");
        end
        $finish;
    end

endmodule
